[hw/rtl/flow_size_histogram_burst_tracker_unit_macros.svh]
// Assertion macros for the flow size histogram and burst tracker checker.
`ifndef FLOW_SIZE_HISTOGRAM_BURST_TRACKER_UNIT_MACROS_SVH
`define FLOW_SIZE_HISTOGRAM_BURST_TRACKER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FSHBT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fshbt checker: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FSHBT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fshbt checker: next-cycle property failed");

`endif

[hw/rtl/fshbt_pkg.sv]
// Shared types, constants and saturating helpers for the flow statistics block.
package fshbt_pkg;

    // Default geometry of the size histogram
    localparam int BIN_COUNT_DEF    = 14;
    localparam int BIN_WIDTH_DEF    = 100;
    localparam int OVERSIZE_LEN_DEF = 1300;

    // Shortest data time reported for a closed burst, in microseconds
    localparam logic [47:0] MIN_DATA_US = 48'd1000;

    // Idle threshold register
    localparam logic [25:0] IDLE_GAP_RESET = 26'd1000000;
    localparam logic [0:0]  REG_IDLE_GAP   = 1'b0;

    // One packet descriptor
    typedef struct packed {
        logic        direction_out;
        logic        is_ipv4;
        logic [7:0]  service_label;
        logic [15:0] payload_len;
        logic [47:0] arrival_time;
    } pkt_t;

    // One statistics result
    typedef struct packed {
        logic        burst_closed;
        logic [47:0] burst_start;
        logic [47:0] burst_data_time;
        logic [47:0] burst_idle_time;
        logic [3:0]  bin_index;
        logic [47:0] bin_value;
        logic [31:0] dir_packets;
        logic [47:0] dir_bytes;
        logic [31:0] dir_data_packets;
        logic [47:0] idle_total;
        logic [7:0]  flow_label;
    } res_t;

    // Size class of a packet, found at input
    typedef struct packed {
        logic empty;
        logic oversize;
    } pkt_class_t;

    // Increment that holds at all ones
    function automatic logic [31:0] sat_inc32(input logic [31:0] a);
        logic [32:0] s;
        s = {1'b0, a} + 33'd1;
        return s[32] ? '1 : s[31:0];
    endfunction

    // 48-bit add that holds at all ones
    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

endpackage

[hw/rtl/fshbt_bin_map.sv]
// Maps a payload length to its size class and histogram bin.
module fshbt_bin_map #(
    parameter int BIN_COUNT    = fshbt_pkg::BIN_COUNT_DEF,
    parameter int BIN_WIDTH    = fshbt_pkg::BIN_WIDTH_DEF,
    parameter int OVERSIZE_LEN = fshbt_pkg::OVERSIZE_LEN_DEF,
    localparam int IW          = $clog2(BIN_COUNT + 1)
) (
    input  logic [15:0]            len,
    output fshbt_pkg::pkt_class_t  cls,
    output logic [IW-1:0]          bin_idx
);

    // Reciprocal of the bin width, exact for every 16-bit length
    localparam int SHIFT = 16 + $clog2(BIN_WIDTH);
    localparam longint RECIP = ((longint'(1) <<< SHIFT) + BIN_WIDTH - 1) / BIN_WIDTH;
    localparam int PW = SHIFT + 16;

    logic [16:0]   recip;
    logic [PW-1:0] prod;
    logic [15:0]   quot;
    logic [IW-1:0] capped;

    assign recip = 17'(RECIP);
    assign prod  = PW'(len) * PW'(recip);
    assign quot  = prod[SHIFT +: 16];

    // len/width + 1, held in the last regular bin
    always_comb
    begin
        if (quot >= 16'(BIN_COUNT - 2))
            capped = IW'(BIN_COUNT - 1);
        else
            capped = IW'(quot) + IW'(1);
    end

    assign cls.empty    = (len == 16'd0);
    assign cls.oversize = (len >= 16'(OVERSIZE_LEN));

    always_comb
    begin
        if (cls.empty)
            bin_idx = '0;
        else if (cls.oversize)
            bin_idx = IW'(BIN_COUNT);
        else
            bin_idx = capped;
    end

endmodule

[hw/rtl/fshbt_bin_mem.sv]
// Histogram count store: one read and one write port, per-entry valid bits.
module fshbt_bin_mem #(
    parameter int DEPTH = 2 * fshbt_pkg::BIN_COUNT_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data
);

    logic [31:0]      mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [31:0]      rd_data_reg;

    // Entry valid bits: an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (wr_en)
            vld_reg[wr_addr] <= 1'b1;
    end

    // Storage and registered read, write data forwarded on an address match
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else if (vld_reg[rd_addr])
                rd_data_reg <= mem[rd_addr];
            else
                rd_data_reg <= '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/fshbt_flow_core.sv]
// Flow state and the single-pass update that forms one result per packet.
module fshbt_flow_core #(
    parameter int BIN_COUNT = fshbt_pkg::BIN_COUNT_DEF,
    localparam int IW       = $clog2(BIN_COUNT + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd,
    input  logic [25:0]           idle_gap,
    input  fshbt_pkg::pkt_t       pkt,
    input  fshbt_pkg::pkt_class_t cls,
    input  logic [IW-1:0]         bin_idx,
    input  logic [31:0]           bin_cnt,
    output logic                  bin_wr_en,
    output logic [31:0]           bin_wr_data,
    output fshbt_pkg::res_t       res
);

    logic        first_seen_reg;
    logic [47:0] last_time_reg;
    logic [47:0] idle_sum_reg;
    logic [31:0] pkt_cnt_reg  [2];
    logic [47:0] byte_tot_reg [2];
    logic [31:0] data_cnt_reg [2];
    logic [47:0] ovs_reg      [2];
    logic        label_known_reg;
    logic [7:0]  label_value_reg;
    logic        burst_enabled_reg;
    logic        burst_open_reg;
    logic [47:0] burst_begin_reg;

    logic        d;
    logic [47:0] now;
    logic [47:0] len48;
    logic [31:0] pkt_cnt_next;
    logic [47:0] byte_tot_next;
    logic [31:0] data_cnt_next;
    logic [47:0] ovs_next;
    logic        take_label;
    logic [7:0]  label_value_next;
    logic        enabled_now;
    logic [48:0] diff;
    logic        forward;
    logic [47:0] gap;
    logic        idle;
    logic [47:0] idle_sum_next;
    logic [48:0] span;
    logic [47:0] span_val;
    logic [47:0] data_time;
    logic        closed;
    logic        restart;
    logic [IW+3:0] idx_ext;

    assign d     = pkt.direction_out;
    assign now   = pkt.arrival_time;
    assign len48 = {32'b0, pkt.payload_len};

    // Per-direction counters
    assign pkt_cnt_next  = fshbt_pkg::sat_inc32(pkt_cnt_reg[d]);
    assign byte_tot_next = fshbt_pkg::sat_add48(byte_tot_reg[d], len48);
    assign data_cnt_next = cls.empty ? data_cnt_reg[d] : fshbt_pkg::sat_inc32(data_cnt_reg[d]);
    assign ovs_next      = fshbt_pkg::sat_add48(ovs_reg[d], len48);

    // Histogram count goes back to the store unless oversize
    assign bin_wr_en   = upd && !cls.oversize;
    assign bin_wr_data = fshbt_pkg::sat_inc32(bin_cnt);

    // Label fixed by the first outgoing packet
    assign take_label       = d && !label_known_reg;
    assign label_value_next = take_label ? (pkt.is_ipv4 ? pkt.service_label : 8'd0)
                                         : label_value_reg;
    assign enabled_now      = burst_enabled_reg || (take_label && (label_value_next != 8'd0));

    // Gap since the previous packet; a backwards timestamp is never idle
    assign diff    = {1'b0, now} - {1'b0, last_time_reg};
    assign forward = first_seen_reg && !diff[48];
    assign gap     = forward ? diff[47:0] : 48'd0;
    assign idle    = forward && (gap > {22'b0, idle_gap});
    assign idle_sum_next = idle ? fshbt_pkg::sat_add48(idle_sum_reg, gap) : idle_sum_reg;

    // Data time of the burst being closed
    assign span      = {1'b0, last_time_reg} - {1'b0, burst_begin_reg};
    assign span_val  = span[48] ? 48'd0 : span[47:0];
    assign data_time = (span_val < fshbt_pkg::MIN_DATA_US) ? fshbt_pkg::MIN_DATA_US : span_val;
    assign closed    = enabled_now && burst_open_reg && idle;
    assign restart   = enabled_now && (!burst_open_reg || idle);

    // State update on each transfer into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_seen_reg    <= 1'b0;
            last_time_reg     <= '0;
            idle_sum_reg      <= '0;
            pkt_cnt_reg       <= '{default: '0};
            byte_tot_reg      <= '{default: '0};
            data_cnt_reg      <= '{default: '0};
            ovs_reg           <= '{default: '0};
            label_known_reg   <= 1'b0;
            label_value_reg   <= '0;
            burst_enabled_reg <= 1'b0;
            burst_open_reg    <= 1'b0;
            burst_begin_reg   <= '0;
        end
        else if (upd)
        begin
            first_seen_reg    <= 1'b1;
            last_time_reg     <= now;
            idle_sum_reg      <= idle_sum_next;
            pkt_cnt_reg[d]    <= pkt_cnt_next;
            byte_tot_reg[d]   <= byte_tot_next;
            data_cnt_reg[d]   <= data_cnt_next;
            if (cls.oversize)
                ovs_reg[d]    <= ovs_next;
            label_known_reg   <= label_known_reg | d;
            label_value_reg   <= label_value_next;
            burst_enabled_reg <= enabled_now;
            burst_open_reg    <= burst_open_reg | enabled_now;
            if (restart)
                burst_begin_reg <= now;
        end
    end

    // Result fields
    assign idx_ext = {4'b0, bin_idx};

    always_comb
    begin
        res.burst_closed     = closed;
        res.burst_start      = closed ? burst_begin_reg : 48'd0;
        res.burst_data_time  = closed ? data_time : 48'd0;
        res.burst_idle_time  = closed ? gap : 48'd0;
        res.bin_index        = idx_ext[3:0];
        res.bin_value        = cls.oversize ? ovs_next : {16'b0, bin_wr_data};
        res.dir_packets      = pkt_cnt_next;
        res.dir_bytes        = byte_tot_next;
        res.dir_data_packets = data_cnt_next;
        res.idle_total       = idle_sum_next;
        res.flow_label       = label_value_next;
    end

endmodule

[hw/rtl/flow_size_histogram_burst_tracker_unit.sv]
// Top level of the per-flow size histogram and burst tracker.
//
//  channel | signals                        | moves
//  --------+--------------------------------+------------------------------
//  pkt     | pkt_valid, pkt_ready, pkt      | one packet descriptor
//  res     | res_valid, res_ready, res      | one statistics result
//  apb     | psel penable pwrite paddr ...  | idle_gap_us at address 0
//
// One packet per cycle sustained while results are taken; each packet
// passes the input register, then the result register, before res_valid
// rises. The limit is the read-modify-write of the histogram count store,
// forwarded between packets.
// Reset clears all counters and the count store valid bits at once; no sweep.
// A stalled result holds both stages; the input still takes a packet while
// the input register is empty or moving on.
module flow_size_histogram_burst_tracker_unit #(
    parameter int BIN_COUNT    = fshbt_pkg::BIN_COUNT_DEF,
    parameter int BIN_WIDTH    = fshbt_pkg::BIN_WIDTH_DEF,
    parameter int OVERSIZE_LEN = fshbt_pkg::OVERSIZE_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pkt_valid,
    output logic            pkt_ready,
    input  fshbt_pkg::pkt_t pkt,
    output logic            res_valid,
    input  logic            res_ready,
    output fshbt_pkg::res_t res,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int IW    = $clog2(BIN_COUNT + 1);
    localparam int DEPTH = 2 * BIN_COUNT;
    localparam int AW    = $clog2(DEPTH);

    logic [25:0]           idle_gap_reg;
    logic                  in_vld_reg;
    fshbt_pkg::pkt_t       in_pkt_reg;
    fshbt_pkg::pkt_class_t in_cls_reg;
    logic [IW-1:0]         in_idx_reg;
    logic [AW-1:0]         in_addr_reg;
    logic                  res_vld_reg;
    fshbt_pkg::res_t       res_reg;

    fshbt_pkg::pkt_class_t map_cls;
    logic [IW-1:0]         map_idx;
    logic [AW-1:0]         map_addr;
    logic                  accept;
    logic                  advance;
    logic [31:0]           bin_cnt;
    logic                  bin_wr_en;
    logic [31:0]           bin_wr_data;
    fshbt_pkg::res_t       core_res;
    logic                  cfg_wr;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == fshbt_pkg::REG_IDLE_GAP);
    assign prdata = (paddr[2] == fshbt_pkg::REG_IDLE_GAP) ? {6'b0, idle_gap_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_gap_reg <= fshbt_pkg::IDLE_GAP_RESET;
        else if (cfg_wr)
            idle_gap_reg <= pwdata[25:0];
    end

    // Pipeline flow control
    assign advance   = in_vld_reg && (!res_vld_reg || res_ready);
    assign pkt_ready = !in_vld_reg || advance;
    assign accept    = pkt_valid && pkt_ready;

    // Bin of the arriving packet and its count store address
    fshbt_bin_map #(
        .BIN_COUNT    (BIN_COUNT),
        .BIN_WIDTH    (BIN_WIDTH),
        .OVERSIZE_LEN (OVERSIZE_LEN)
    ) u_bin_map (
        .len     (pkt.payload_len),
        .cls     (map_cls),
        .bin_idx (map_idx)
    );

    assign map_addr = pkt.direction_out ? (AW'(BIN_COUNT) + AW'(map_idx)) : AW'(map_idx);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (pkt_ready)
            in_vld_reg <= pkt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_pkt_reg  <= pkt;
            in_cls_reg  <= map_cls;
            in_idx_reg  <= map_idx;
            in_addr_reg <= map_addr;
        end
    end

    // Histogram counts, read as the packet enters the input register
    // (oversize packets have no count entry)
    fshbt_bin_mem #(
        .DEPTH (DEPTH)
    ) u_bin_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && !map_cls.oversize),
        .rd_addr (map_addr),
        .rd_data (bin_cnt),
        .wr_en   (bin_wr_en),
        .wr_addr (in_addr_reg),
        .wr_data (bin_wr_data)
    );

    fshbt_flow_core #(
        .BIN_COUNT (BIN_COUNT)
    ) u_flow_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (advance),
        .idle_gap    (idle_gap_reg),
        .pkt         (in_pkt_reg),
        .cls         (in_cls_reg),
        .bin_idx     (in_idx_reg),
        .bin_cnt     (bin_cnt),
        .bin_wr_en   (bin_wr_en),
        .bin_wr_data (bin_wr_data),
        .res         (core_res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (advance)
            res_vld_reg <= 1'b1;
        else if (res_ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= core_res;
    end

    assign res_valid = res_vld_reg;
    assign res       = res_reg;

endmodule

[hw/rtl/fshbt_checker.sv]
// Port-level checker for the flow statistics block, bound to the top level.
`include "flow_size_histogram_burst_tracker_unit_macros.svh"

module fshbt_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            pkt_ready,
    input logic            res_valid,
    input logic            res_ready,
    input fshbt_pkg::res_t res
);

    // A stalled result holds
    `FSHBT_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res))

    // Input back-pressure only when a result is waiting
    `FSHBT_ASSERT_NOW(a_ready_stall, !pkt_ready, res_valid && !res_ready)

    // A closed burst reports at least the minimum data time
    `FSHBT_ASSERT_NOW(a_burst_min, res_valid && res.burst_closed, res.burst_data_time >= fshbt_pkg::MIN_DATA_US)

    // Burst fields are zero when no burst closed
    `FSHBT_ASSERT_NOW(a_burst_zero, res_valid && !res.burst_closed, (res.burst_start == 48'd0) && (res.burst_data_time == 48'd0) && (res.burst_idle_time == 48'd0))

    // Every result counts at least the packet that made it
    `FSHBT_ASSERT_NOW(a_counts_live, res_valid, (res.dir_packets != 32'd0) && (res.bin_value != 48'd0))

endmodule

bind flow_size_histogram_burst_tracker_unit fshbt_checker u_fshbt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_ready (pkt_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

[bench/flow_size_histogram_burst_tracker_unit_test.sv]
// Self-checking testbench for the flow size histogram and burst tracker.
`timescale 1ns / 100ps

module flow_size_histogram_burst_tracker_unit_test;

    localparam int CLK_PERIOD   = 8;
    localparam int BIN_COUNT    = fshbt_pkg::BIN_COUNT_DEF;
    localparam int BIN_WIDTH    = fshbt_pkg::BIN_WIDTH_DEF;
    localparam int OVERSIZE_LEN = fshbt_pkg::OVERSIZE_LEN_DEF;
    localparam int PHASE_ITEMS  = 305;
    localparam int PHASES       = 6;
    localparam int DRAIN_PAUSE  = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [2:0] IDLE_GAP_ADDR = 3'(fshbt_pkg::REG_IDLE_GAP) << 2;

    // One directed stimulus row; want is used only when typed is set
    typedef struct {
        fshbt_pkg::pkt_t p;
        bit              typed;
        fshbt_pkg::res_t want;
    } probe_row_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            pkt_valid = 1'b0;
    logic            pkt_ready;
    fshbt_pkg::pkt_t pkt = '0;
    logic            res_valid;
    logic            res_ready = 1'b0;
    fshbt_pkg::res_t res;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [2:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    // Predictor copy of the flow statistics
    logic [25:0] idle_thresh = fshbt_pkg::IDLE_GAP_RESET;
    bit          stat_first = 1'b0;
    logic [47:0] stat_last = '0;
    logic [47:0] stat_idle = '0;
    logic [31:0] stat_pkts [2] = '{default: '0};
    logic [47:0] stat_bytes [2] = '{default: '0};
    logic [31:0] stat_data [2] = '{default: '0};
    logic [31:0] stat_bins [2*BIN_COUNT] = '{default: '0};
    logic [47:0] stat_over [2] = '{default: '0};
    bit          lbl_known = 1'b0;
    logic [7:0]  lbl_value = '0;
    bit          bst_enabled = 1'b0;
    bit          bst_open = 1'b0;
    logic [47:0] bst_begin = '0;

    fshbt_pkg::res_t stats_due [$];
    probe_row_t      probe_rows [$];
    logic [47:0]     arrival_clock = '0;
    int              mismatches = 0;
    int              results_seen = 0;
    int              cycles = 0;
    int              src_odds = 3;
    bit              src_quiet = 1'b0;
    bit              sink_quiet = 1'b0;
    int              hold_cnt = 0;
    int              calm_cnt = 0;

    flow_size_histogram_burst_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_ready (pkt_ready),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** flow_size_histogram_burst_tracker_unit: FAILED **");
            $finish;
        end
    end

    // Counters that hold at all ones
    function automatic logic [31:0] bump32(input logic [31:0] a);
        return (a == '1) ? a : a + 32'd1;
    endfunction

    function automatic logic [47:0] add48_hold(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    // Expected result of one packet; updates the predictor state
    task automatic predict_flow_stats(input fshbt_pkg::pkt_t p, output fshbt_pkg::res_t r);
        int unsigned d;
        int unsigned slot;
        logic [47:0] gap;
        bit          idle;
        d    = p.direction_out;
        r    = '0;
        gap  = '0;
        idle = 1'b0;
        stat_pkts[d]  = bump32(stat_pkts[d]);
        stat_bytes[d] = add48_hold(stat_bytes[d], 48'(p.payload_len));

        // size histogram or oversize sum
        if (p.payload_len == 16'd0)
        begin
            slot = d * BIN_COUNT;
            stat_bins[slot] = bump32(stat_bins[slot]);
            r.bin_index = 4'd0;
            r.bin_value = 48'(stat_bins[slot]);
        end
        else
        begin
            stat_data[d] = bump32(stat_data[d]);
            if (p.payload_len >= OVERSIZE_LEN)
            begin
                stat_over[d] = add48_hold(stat_over[d], 48'(p.payload_len));
                r.bin_index = 4'(BIN_COUNT);
                r.bin_value = stat_over[d];
            end
            else
            begin
                slot = p.payload_len / BIN_WIDTH + 1;
                if (slot > BIN_COUNT - 1)
                    slot = BIN_COUNT - 1;
                r.bin_index = 4'(slot);
                slot = slot + d * BIN_COUNT;
                stat_bins[slot] = bump32(stat_bins[slot]);
                r.bin_value = 48'(stat_bins[slot]);
            end
        end

        // first outgoing packet fixes the label
        if (d == 1 && !lbl_known)
        begin
            lbl_known = 1'b1;
            lbl_value = p.is_ipv4 ? p.service_label : 8'd0;
            if (lbl_value != 8'd0)
                bst_enabled = 1'b1;
        end

        // idle gap; a backward timestamp never counts
        if (stat_first && p.arrival_time >= stat_last)
        begin
            gap  = p.arrival_time - stat_last;
            idle = gap > 48'(idle_thresh);
        end
        if (idle)
            stat_idle = add48_hold(stat_idle, gap);

        // burst open / close
        if (bst_enabled)
        begin
            if (!bst_open)
            begin
                bst_open  = 1'b1;
                bst_begin = p.arrival_time;
            end
            else if (idle)
            begin
                r.burst_closed    = 1'b1;
                r.burst_start     = bst_begin;
                r.burst_data_time = (stat_last >= bst_begin) ? stat_last - bst_begin : '0;
                if (r.burst_data_time < fshbt_pkg::MIN_DATA_US)
                    r.burst_data_time = fshbt_pkg::MIN_DATA_US;
                r.burst_idle_time = gap;
                bst_begin         = p.arrival_time;
            end
        end

        stat_last  = p.arrival_time;
        stat_first = 1'b1;
        r.dir_packets      = stat_pkts[d];
        r.dir_bytes        = stat_bytes[d];
        r.dir_data_packets = stat_data[d];
        r.idle_total       = stat_idle;
        r.flow_label       = lbl_known ? lbl_value : 8'd0;
    endtask

    function automatic bit field_off(input string name, input logic [47:0] want,
                                     input logic [47:0] got);
        if (want === got)
            return 1'b0;
        if (mismatches < 10)
            $display("result %0d %s: expected %0h, got %0h", results_seen, name, want, got);
        return 1'b1;
    endfunction

    // Result channel check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        fshbt_pkg::res_t want;
        bit              bad;
        if (rst_n && res_valid && res_ready)
        begin
            if (stats_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("result %0d: transfer with nothing expected", results_seen);
                mismatches++;
            end
            else
            begin
                want = stats_due.pop_front();
                bad  = 1'b0;
                bad |= field_off("burst_closed", 48'(want.burst_closed), 48'(res.burst_closed));
                bad |= field_off("burst_start", want.burst_start, res.burst_start);
                bad |= field_off("burst_data_time", want.burst_data_time, res.burst_data_time);
                bad |= field_off("burst_idle_time", want.burst_idle_time, res.burst_idle_time);
                bad |= field_off("bin_index", 48'(want.bin_index), 48'(res.bin_index));
                bad |= field_off("bin_value", want.bin_value, res.bin_value);
                bad |= field_off("dir_packets", 48'(want.dir_packets), 48'(res.dir_packets));
                bad |= field_off("dir_bytes", want.dir_bytes, res.dir_bytes);
                bad |= field_off("dir_data_packets", 48'(want.dir_data_packets),
                                 48'(res.dir_data_packets));
                bad |= field_off("idle_total", want.idle_total, res.idle_total);
                bad |= field_off("flow_label", 48'(want.flow_label), 48'(res.flow_label));
                if (bad)
                    mismatches++;
            end
            results_seen++;
        end
    end

    // Receiver pacing: stall bursts, calm stretches, none at the end
    always @(posedge clk)
    begin : sink_pacing
        bit take;
        take = 1'b1;
        if (sink_quiet)
        begin
            hold_cnt = 0;
            take     = 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt--;
            take = 1'b0;
        end
        else if (calm_cnt > 0)
            calm_cnt--;
        else
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    hold_cnt = $urandom_range(1, 16) - 1;
                    take     = 1'b0;
                end
                1: calm_cnt = $urandom_range(20, 80);
                default: take = 1'b1;
            endcase
        end
        res_ready <= take;
    end

    // One APB setup plus access, then the bus is released
    task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= IDLE_GAP_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic confirm_idle_gap;
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== 32'(idle_thresh))
        begin
            if (mismatches < 10)
                $display("idle_gap_us readback: expected %0h, got %0h", idle_thresh, rd);
            mismatches++;
        end
    endtask

    task automatic set_idle_gap(input logic [31:0] value);
        logic [31:0] rd;
        apb_access(1'b1, value, rd);
        idle_thresh = value[25:0];
        confirm_idle_gap();
    endtask

    task automatic wait_drained;
        while (stats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Offer one packet, with an optional sender gap first
    task automatic push_packet(input fshbt_pkg::pkt_t p, input bit typed,
                               input fshbt_pkg::res_t typed_want);
        fshbt_pkg::res_t guess;
        if (!src_quiet && src_odds != 0 && $urandom_range(0, src_odds) == 0)
        begin
            pkt_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        pkt_valid <= 1'b1;
        pkt       <= p;
        do
            @(posedge clk);
        while (!pkt_ready);
        predict_flow_stats(p, guess);
        stats_due = {stats_due, (typed ? typed_want : guess)};
    endtask

    function automatic fshbt_pkg::pkt_t make_pkt(input bit d, input bit v4,
                                                 input logic [7:0] svc, input logic [15:0] len,
                                                 input logic [47:0] t);
        fshbt_pkg::pkt_t p;
        p.direction_out = d;
        p.is_ipv4       = v4;
        p.service_label = svc;
        p.payload_len   = len;
        p.arrival_time  = t;
        return p;
    endfunction

    // Typed result without a closed burst
    function automatic fshbt_pkg::res_t make_res(input logic [3:0] bin, input logic [47:0] val,
                                                 input logic [31:0] pk, input logic [47:0] by,
                                                 input logic [31:0] dp, input logic [47:0] idl,
                                                 input logic [7:0] lbl);
        fshbt_pkg::res_t r;
        r = '0;
        r.bin_index        = bin;
        r.bin_value        = val;
        r.dir_packets      = pk;
        r.dir_bytes        = by;
        r.dir_data_packets = dp;
        r.idle_total       = idl;
        r.flow_label       = lbl;
        return r;
    endfunction

    function automatic void add_row(input fshbt_pkg::pkt_t p, input bit typed,
                                    input fshbt_pkg::res_t want);
        probe_row_t row;
        row.p     = p;
        row.typed = typed;
        row.want  = want;
        probe_rows = {probe_rows, row};
    endfunction

    function automatic logic [15:0] pick_len;
        case ($urandom_range(0, 9))
            0, 1: return 16'd0;
            2: return 16'(OVERSIZE_LEN);
            3: return 16'(OVERSIZE_LEN - 1);
            4: return 16'hFFFF;
            5: return 16'($urandom_range(1, 13) * BIN_WIDTH - $urandom_range(0, 1));
            6: return 16'($urandom_range(OVERSIZE_LEN, 65535));
            default: return 16'($urandom_range(1, OVERSIZE_LEN - 1));
        endcase
    endfunction

    // Next timestamp: mostly forward steps around the idle threshold
    task automatic next_arrival(input bit wide, output logic [47:0] t);
        logic [47:0] step;
        logic [47:0] back;
        logic [47:0] th;
        th   = 48'(idle_thresh);
        step = '0;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5: step = 48'($urandom_range(0, 20));
            6, 7: step = th;
            8, 9: step = th + 48'd1;
            10: step = (th != '0) ? th - 48'd1 : '0;
            11: step = 48'($urandom_range(0, 32'(idle_thresh) * 2 + 2));
            12:
            begin
                back = 48'($urandom_range(1, 100000));
                if (back > arrival_clock)
                    back = arrival_clock;
                arrival_clock = arrival_clock - back;
            end
            13: step = '0;
            14: step = wide ? 48'({$urandom, $urandom}) : 48'($urandom);
            default:
            begin
                if (!wide)
                    step = 48'($urandom_range(0, 32'(idle_thresh) * 3));
                else if ($urandom_range(0, 1) == 0)
                    arrival_clock = '1;
                else
                    arrival_clock = 48'({$urandom, $urandom});
            end
        endcase
        arrival_clock = arrival_clock + step;
        t = arrival_clock;
    endtask

    // Main sequence
    initial
    begin : main_flow
        logic [31:0]     phase_cfg [PHASES];
        fshbt_pkg::pkt_t p;
        logic [47:0]     t;
        int              odds_pick [3];

        odds_pick = '{0, 3, 8};
        phase_cfg[0] = 32'd0;
        phase_cfg[1] = 32'hFFFF_FFFF;
        phase_cfg[2] = 32'd60000000;
        phase_cfg[3] = $urandom_range(1, 5000);
        phase_cfg[4] = $urandom_range(0, 60000000);
        phase_cfg[5] = $urandom_range(1, 2000000);

        // directed table: size extremes, idle boundary, label fix, burst closes
        add_row(make_pkt(0, 1, 8'hFF, 16'd0, 48'd0), 1,
                make_res(4'd0, 48'd1, 32'd1, 48'd0, 32'd0, 48'd0, 8'd0));
        add_row(make_pkt(0, 0, 8'h00, 16'hFFFF, 48'd10), 1,
                make_res(4'd14, 48'd65535, 32'd2, 48'd65535, 32'd1, 48'd0, 8'd0));
        add_row(make_pkt(0, 1, 8'h3C, 16'd1299, 48'd20), 1,
                make_res(4'd13, 48'd1, 32'd3, 48'd66834, 32'd2, 48'd0, 8'd0));
        add_row(make_pkt(0, 0, 8'h81, 16'd1300, 48'd30), 1,
                make_res(4'd14, 48'd66835, 32'd4, 48'd68134, 32'd3, 48'd0, 8'd0));
        add_row(make_pkt(0, 1, 8'h01, 16'd1, 48'd40), 1,
                make_res(4'd1, 48'd1, 32'd5, 48'd68135, 32'd4, 48'd0, 8'd0));
        add_row(make_pkt(0, 0, 8'h7E, 16'd99, 48'd50), 1,
                make_res(4'd1, 48'd2, 32'd6, 48'd68234, 32'd5, 48'd0, 8'd0));
        add_row(make_pkt(0, 1, 8'h02, 16'd100, 48'd60), 1,
                make_res(4'd2, 48'd1, 32'd7, 48'd68334, 32'd6, 48'd0, 8'd0));
        add_row(make_pkt(0, 0, 8'h55, 16'd1200, 48'd70), 1,
                make_res(4'd13, 48'd2, 32'd8, 48'd69534, 32'd7, 48'd0, 8'd0));
        // gap equal to the threshold is not idle, one more is
        add_row(make_pkt(0, 1, 8'h10, 16'd0, 48'd1000070), 1,
                make_res(4'd0, 48'd2, 32'd9, 48'd69534, 32'd7, 48'd0, 8'd0));
        add_row(make_pkt(0, 1, 8'h10, 16'd0, 48'd2000071), 1,
                make_res(4'd0, 48'd3, 32'd10, 48'd69534, 32'd7, 48'd1000001, 8'd0));
        // timestamp going backwards
        add_row(make_pkt(0, 0, 8'h20, 16'd0, 48'd5), 1,
                make_res(4'd0, 48'd4, 32'd11, 48'd69534, 32'd7, 48'd1000001, 8'd0));
        // first outgoing packet fixes the label and opens a burst
        add_row(make_pkt(1, 1, 8'hA5, 16'd0, 48'd100), 1,
                make_res(4'd0, 48'd1, 32'd1, 48'd0, 32'd0, 48'd1000001, 8'hA5));
        add_row(make_pkt(1, 1, 8'h11, 16'd500, 48'd200), 0, '0);
        add_row(make_pkt(0, 0, 8'hFF, 16'd1299, 48'd1300000), 0, '0);
        add_row(make_pkt(1, 1, 8'h00, 16'd1000, 48'd1300500), 0, '0);
        add_row(make_pkt(1, 0, 8'hFF, 16'hFFFF, 48'd3000000), 0, '0);
        add_row(make_pkt(1, 1, 8'h42, 16'd20, 48'd3005000), 0, '0);
        add_row(make_pkt(0, 1, 8'h00, 16'd0, 48'd3010000), 0, '0);
        add_row(make_pkt(0, 0, 8'h99, 16'd1300, 48'd5000000), 0, '0);
        // backward time inside a burst: data time floors at the minimum
        add_row(make_pkt(1, 1, 8'hEE, 16'd7, 48'd4000000), 0, '0);
        add_row(make_pkt(1, 0, 8'h33, 16'd250, 48'd6000001), 0, '0);
        add_row(make_pkt(0, 1, 8'h00, 16'd1, 48'd6000001), 0, '0);

        // reset
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        confirm_idle_gap();

        foreach (probe_rows[i])
            push_packet(probe_rows[i].p, probe_rows[i].typed, probe_rows[i].want);
        pkt_valid <= 1'b0;
        arrival_clock = stat_last;

        // random phases, one idle threshold each
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            set_idle_gap(phase_cfg[ph]);
            if (ph == PHASES - 1)
            begin
                src_quiet  = 1'b1;
                sink_quiet = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 64 == 0)
                    src_odds = odds_pick[$urandom_range(0, 2)];
                next_arrival(ph == PHASES - 1, t);
                p = make_pkt($urandom_range(0, 1), $urandom_range(0, 1),
                             8'($urandom_range(0, 255)), pick_len(), t);
                push_packet(p, 1'b0, '0);
            end
            pkt_valid <= 1'b0;
        end

        wait_drained();
        if (mismatches == 0 && stats_due.size() == 0)
            $display("** flow_size_histogram_burst_tracker_unit: PASSED **");
        else
            $display("** flow_size_histogram_burst_tracker_unit: FAILED **");
        $finish;
    end

endmodule
